FILE: rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// transfer structs, request codes, sequencer states, character codes
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  typedef enum logic [1:0] {
    REQ_PROC  = 2'd0,
    REQ_RAW   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  char_code;
    logic [11:0] read_addr;
  } tcw_in_t;

  typedef struct packed {
    logic [11:0] cursor_offset;
    logic [15:0] read_data;
  } tcw_out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_PUT,
    S_PUT_WR,
    S_NL,
    S_SCR_COPY,
    S_SCR_FILL,
    S_CLR_FILL,
    S_RD_WAIT,
    S_RES,
    S_OUT
  } state_e;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_BLANK   = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_COLOR = 8'h63;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;

  localparam logic [7:0]  ATTR_RESET  = 8'h07;
  localparam logic [15:0] BLANK_RESET = 16'h0700;
  localparam int          COLS_RESET  = 80;
  localparam int          ROWS_RESET  = 25;

endpackage

FILE: rtl/text_console_writer_top.sv
// text_console_writer_top: each request is decoded; printable chars, raw chars and an unknown
//   escape are written to the screen ram, a wrap or newline may scroll, a clear fills
//   columns*rows cells, then the cursor offset is formed and the result is registered.
// one request at a time, the input being ready only in the idle state, set by the sequencer
//   sharing one multiply-add unit and one ram write port cell by cell.
// reset: a clearing pass writes zero to every screen ram cell, input not ready meanwhile
`timescale 1ns / 1ps

module text_console_writer_top #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int Cells   = MAX_COLS * MAX_ROWS;
  localparam int AddrW   = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CntW    = $clog2(Cells + 1);
  localparam int NcW     = $clog2(MAX_COLS + 1);
  localparam int NrW     = $clog2(MAX_ROWS + 1);
  localparam int ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NcReset = (tcw_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tcw_pkg::COLS_RESET;
  localparam int NrReset = (tcw_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tcw_pkg::ROWS_RESET;

  logic [NcW-1:0] nc_q, nc_d;
  logic [NrW-1:0] nr_q, nr_d;
  logic [15:0]    blank_q;

  logic             mac_en;
  logic [NrW-1:0]   mac_row;
  logic [ColW-1:0]  mac_col;
  logic [CntW-1:0]  mac_prod;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  assign cfg_ready_o = 1'b1;

  // effective geometry is kept clamped to 1..max
  always_comb begin
    if (cfg_data_i[7:0] == 8'd0) begin
      nc_d = NcW'(1);
    end else if (int'(cfg_data_i[7:0]) > MAX_COLS) begin
      nc_d = NcW'(MAX_COLS);
    end else begin
      nc_d = NcW'(cfg_data_i[7:0]);
    end
    if (cfg_data_i[5:0] == 6'd0) begin
      nr_d = NrW'(1);
    end else if (int'(cfg_data_i[5:0]) > MAX_ROWS) begin
      nr_d = NrW'(MAX_ROWS);
    end else begin
      nr_d = NrW'(cfg_data_i[5:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q    <= NcW'(NcReset);
      nr_q    <= NrW'(NrReset);
      blank_q <= tcw_pkg::BLANK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tcw_pkg::CFG_COLUMNS: nc_q    <= nc_d;
        tcw_pkg::CFG_ROWS:    nr_q    <= nr_d;
        tcw_pkg::CFG_BLANK:   blank_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tcw_ram #(
    .Width(16),
    .Depth(Cells)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  tcw_mac #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .row_i (mac_row),
    .col_i (mac_col),
    .nc_i  (nc_q),
    .prod_o(mac_prod)
  );

  tcw_seq #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .nc_i       (nc_q),
    .nr_i       (nr_q),
    .blank_i    (blank_q),
    .mac_en_o   (mac_en),
    .mac_row_o  (mac_row),
    .mac_col_o  (mac_col),
    .mac_prod_i (mac_prod),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

endmodule

FILE: rtl/tcw_ram.sv
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tcw_mac.sv
// tcw_mac: shared multiply-add unit, prod = row * columns + col, registered
// used for cell offsets, clear length and scroll copy length
`timescale 1ns / 1ps

module tcw_mac #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]               row_i,
  input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] col_i,
  input  logic [$clog2(MAX_COLS + 1)-1:0]               nc_i,
  output logic [$clog2(MAX_COLS * MAX_ROWS + 1)-1:0]    prod_o
);

  localparam int NcW  = $clog2(MAX_COLS + 1);
  localparam int NrW  = $clog2(MAX_ROWS + 1);
  localparam int CntW = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int PW   = NrW + NcW + 1;

  logic [PW-1:0]   full;
  logic [CntW-1:0] prod_q;

  assign full = PW'(row_i) * PW'(nc_i) + PW'(col_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= CntW'(full);
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/tcw_seq.sv
// tcw_seq: request sequencer, cursor and escape state, copy and fill sweeps
// drives the screen ram and the shared multiply-add unit; uses tcw_pkg
`timescale 1ns / 1ps

module tcw_seq #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  tcw_pkg::tcw_in_t                                 in_data_i,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output tcw_pkg::tcw_out_t                                out_data_o,
  input  logic [$clog2(MAX_COLS + 1)-1:0]                  nc_i,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]                  nr_i,
  input  logic [15:0]                                      blank_i,
  output logic                                             mac_en_o,
  output logic [$clog2(MAX_ROWS + 1)-1:0]                  mac_row_o,
  output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] mac_col_o,
  input  logic [$clog2(MAX_COLS * MAX_ROWS + 1)-1:0]       mac_prod_i,
  output logic                                             mem_we_o,
  output logic [(MAX_COLS * MAX_ROWS > 1 ? $clog2(MAX_COLS * MAX_ROWS) : 1)-1:0] mem_waddr_o,
  output logic [15:0]                                      mem_wdata_o,
  output logic                                             mem_re_o,
  output logic [(MAX_COLS * MAX_ROWS > 1 ? $clog2(MAX_COLS * MAX_ROWS) : 1)-1:0] mem_raddr_o,
  input  logic [15:0]                                      mem_rdata_i
);

  localparam int Cells = MAX_COLS * MAX_ROWS;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CntW  = $clog2(Cells + 1);
  localparam int NcW   = $clog2(MAX_COLS + 1);
  localparam int NrW   = $clog2(MAX_ROWS + 1);
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  tcw_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [7:0]        attr_q, attr_d;
  logic              esc_q, esc_d;
  logic              color_q, color_d;
  tcw_pkg::req_e     req_q, req_d;
  logic [7:0]        ch_q, ch_d;
  logic [7:0]        put_ch_q, put_ch_d;
  logic              second_q, second_d;
  logic              rd_ok_q, rd_ok_d;
  logic [AddrW-1:0]  raddr_q, raddr_d;
  logic [15:0]       rd_q, rd_d;
  logic              out_valid_q, out_valid_d;
  tcw_pkg::tcw_out_t out_q, out_d;

  logic [ColW-1:0] nc_m1;
  logic [RowW-1:0] nr_m1;
  logic [NcW-1:0]  col_p1;
  logic [NrW-1:0]  row_p1;
  logic            wrap;
  logic            scroll;
  logic [CntW-1:0] fill_end;

  assign nc_m1    = ColW'(nc_i - NcW'(1));
  assign nr_m1    = RowW'(nr_i - NrW'(1));
  assign col_p1   = NcW'(col_q) + NcW'(1);
  assign row_p1   = NrW'(row_q) + NrW'(1);
  assign wrap     = col_p1 >= nc_i;
  assign scroll   = row_p1 >= nr_i;
  assign fill_end = mac_prod_i + CntW'(nc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= tcw_pkg::ATTR_RESET;
      esc_q       <= 1'b0;
      color_q     <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      attr_q      <= attr_d;
      esc_q       <= esc_d;
      color_q     <= color_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    ch_q     <= ch_d;
    put_ch_q <= put_ch_d;
    rd_ok_q  <= rd_ok_d;
    raddr_q  <= raddr_d;
    rd_q     <= rd_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    attr_d      = attr_q;
    esc_d       = esc_q;
    color_d     = color_q;
    req_d       = req_q;
    ch_d        = ch_q;
    put_ch_d    = put_ch_q;
    second_d    = second_q;
    rd_ok_d     = rd_ok_q;
    raddr_d     = raddr_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mac_en_o    = 1'b0;
    mac_row_o   = '0;
    mac_col_o   = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      tcw_pkg::S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(cnt_q);
        if (cnt_q == CntW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      tcw_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = in_data_i.req_type;
          ch_d     = in_data_i.char_code;
          put_ch_d = in_data_i.char_code;
          second_d = 1'b0;
          raddr_d  = AddrW'(in_data_i.read_addr);
          rd_ok_d  = int'(in_data_i.read_addr) < Cells;
          rd_d     = '0;
          // clamp a cursor left outside a changed geometry
          if (int'(col_q) >= int'(nc_i)) begin
            col_d = nc_m1;
          end
          if (int'(row_q) >= int'(nr_i)) begin
            row_d = nr_m1;
          end
          state_d = tcw_pkg::S_DECODE;
        end
      end

      tcw_pkg::S_DECODE: begin
        case (req_q)
          tcw_pkg::REQ_READ: begin
            mem_re_o    = 1'b1;
            mem_raddr_o = raddr_q;
            state_d     = tcw_pkg::S_RD_WAIT;
          end
          tcw_pkg::REQ_CLEAR: begin
            mac_en_o  = 1'b1;
            mac_row_o = nr_i;
            cnt_d     = '0;
            state_d   = tcw_pkg::S_CLR_FILL;
          end
          tcw_pkg::REQ_RAW: begin
            state_d = tcw_pkg::S_PUT;
          end
          default: begin
            state_d = tcw_pkg::S_RES;
            if (esc_q) begin
              if (color_q) begin
                attr_d  = ch_q;
                esc_d   = 1'b0;
                color_d = 1'b0;
              end else if (ch_q == tcw_pkg::CH_COLOR) begin
                color_d = 1'b1;
              end else begin
                // unknown escape: emit ESC, then the byte
                put_ch_d = tcw_pkg::CH_ESC;
                second_d = 1'b1;
                esc_d    = 1'b0;
                state_d  = tcw_pkg::S_PUT;
              end
            end else if (ch_q == tcw_pkg::CH_NL) begin
              state_d = tcw_pkg::S_NL;
            end else if (ch_q == tcw_pkg::CH_CR) begin
              col_d = '0;
            end else if (ch_q == tcw_pkg::CH_BS) begin
              if (col_q != '0) begin
                col_d = col_q - ColW'(1);
              end
            end else if (ch_q == tcw_pkg::CH_ESC) begin
              esc_d   = 1'b1;
              color_d = 1'b0;
            end else begin
              state_d = tcw_pkg::S_PUT;
            end
          end
        endcase
      end

      tcw_pkg::S_PUT: begin
        mac_en_o  = 1'b1;
        mac_row_o = NrW'(row_q);
        mac_col_o = col_q;
        state_d   = tcw_pkg::S_PUT_WR;
      end

      tcw_pkg::S_PUT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(mac_prod_i);
        mem_wdata_o = {attr_q, put_ch_q};
        if (wrap) begin
          state_d = tcw_pkg::S_NL;
        end else begin
          col_d    = col_q + ColW'(1);
          state_d  = second_q ? tcw_pkg::S_PUT : tcw_pkg::S_RES;
          second_d = 1'b0;
          put_ch_d = ch_q;
        end
      end

      tcw_pkg::S_NL: begin
        col_d = '0;
        if (scroll) begin
          mac_en_o  = 1'b1;
          mac_row_o = NrW'(nr_m1);
          cnt_d     = '0;
          state_d   = tcw_pkg::S_SCR_COPY;
        end else begin
          row_d    = row_q + RowW'(1);
          state_d  = second_q ? tcw_pkg::S_PUT : tcw_pkg::S_RES;
          second_d = 1'b0;
          put_ch_d = ch_q;
        end
      end

      tcw_pkg::S_SCR_COPY: begin
        // read one row ahead, write the cell read in the previous cycle
        if (cnt_q != '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(cnt_q - CntW'(1));
          mem_wdata_o = mem_rdata_i;
        end
        if (cnt_q != mac_prod_i) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(cnt_q + CntW'(nc_i));
          cnt_d       = cnt_q + CntW'(1);
        end else begin
          state_d = tcw_pkg::S_SCR_FILL;
        end
      end

      tcw_pkg::S_SCR_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(cnt_q);
        mem_wdata_o = blank_i;
        if (cnt_q + CntW'(1) == fill_end) begin
          state_d  = second_q ? tcw_pkg::S_PUT : tcw_pkg::S_RES;
          second_d = 1'b0;
          put_ch_d = ch_q;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      tcw_pkg::S_CLR_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(cnt_q);
        mem_wdata_o = blank_i;
        if (cnt_q + CntW'(1) == mac_prod_i) begin
          col_d   = '0;
          row_d   = '0;
          state_d = tcw_pkg::S_RES;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      tcw_pkg::S_RD_WAIT: begin
        rd_d    = rd_ok_q ? mem_rdata_i : 16'h0000;
        state_d = tcw_pkg::S_RES;
      end

      tcw_pkg::S_RES: begin
        mac_en_o  = 1'b1;
        mac_row_o = NrW'(row_q);
        mac_col_o = col_q;
        state_d   = tcw_pkg::S_OUT;
      end

      tcw_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.cursor_offset = 12'(mac_prod_i);
          out_d.read_data     = rd_q;
          out_valid_d         = 1'b1;
          state_d             = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == tcw_pkg::S_DECODE)
    else $error("accepted request not decoded");

  a_cursor_in_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::S_RES |-> (int'(col_q) < int'(nc_i)) && (int'(row_q) < int'(nr_i)))
    else $error("cursor outside geometry at result");

  a_copy_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("ram read and write hit the same cell");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::S_OUT && out_valid_q && !out_ready_i |=> state_q == tcw_pkg::S_OUT)
    else $error("result register overwritten before transfer");
`endif

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for text_console_writer_top
// a screen scoreboard class predicts cursor offset and cell reads per request
// depends on tcw_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_CAP = 20;

  class screen_scoreboard;
    bit [15:0] cells [STORE_CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    bit [15:0] attr;
    bit esc_open;
    bit esc_color;
    bit [7:0] cols_reg;
    bit [5:0] rows_reg;
    bit [15:0] blank;
    tcw_pkg::tcw_out_t console_reports [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_col = 0;
      cur_row = 0;
      attr = {tcw_pkg::ATTR_RESET, 8'h00};
      esc_open = 1'b0;
      esc_color = 1'b0;
      cols_reg = 8'(tcw_pkg::COLS_RESET);
      rows_reg = 6'(tcw_pkg::ROWS_RESET);
      blank = tcw_pkg::BLANK_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tcw_pkg::CFG_COLUMNS: cols_reg = val[7:0];
        tcw_pkg::CFG_ROWS:    rows_reg = val[5:0];
        tcw_pkg::CFG_BLANK:   blank = val;
        default: ;
      endcase
    endfunction

    function void scroll_up();
      int unsigned nc;
      int unsigned keep;
      nc = eff_cols();
      keep = nc * (eff_rows() - 1);
      for (int unsigned i = 0; i < keep; i++) cells[i] = cells[i + nc];
      for (int unsigned i = 0; i < nc; i++) cells[keep + i] = blank;
    endfunction

    function void line_feed();
      cur_col = 0;
      if (cur_row + 1 >= eff_rows()) scroll_up();
      else cur_row++;
    endfunction

    function void put_cell(bit [7:0] ch);
      cells[cur_row * eff_cols() + cur_col] = attr | {8'h00, ch};
      cur_col++;
      if (cur_col >= eff_cols()) line_feed();
    endfunction

    function void take_byte(bit [7:0] ch);
      if (esc_open) begin
        if (esc_color) begin
          attr = {ch, 8'h00};
          esc_open = 1'b0;
          esc_color = 1'b0;
        end else if (ch == tcw_pkg::CH_COLOR) begin
          esc_color = 1'b1;
        end else begin
          // unknown escape: both bytes land as cells
          put_cell(tcw_pkg::CH_ESC);
          put_cell(ch);
          esc_open = 1'b0;
        end
      end else begin
        case (ch)
          tcw_pkg::CH_NL: line_feed();
          tcw_pkg::CH_CR: cur_col = 0;
          tcw_pkg::CH_BS: if (cur_col > 0) cur_col--;
          tcw_pkg::CH_ESC: begin
            esc_open = 1'b1;
            esc_color = 1'b0;
          end
          default: put_cell(ch);
        endcase
      end
    endfunction

    function void accept_request(tcw_pkg::tcw_in_t req);
      int unsigned nc;
      int unsigned nr;
      tcw_pkg::tcw_out_t rep;
      nc = eff_cols();
      nr = eff_rows();
      // geometry may have shrunk under the cursor
      if (cur_col >= nc) cur_col = nc - 1;
      if (cur_row >= nr) cur_row = nr - 1;
      rep.read_data = '0;
      case (req.req_type)
        tcw_pkg::REQ_PROC: take_byte(req.char_code);
        tcw_pkg::REQ_RAW:  put_cell(req.char_code);
        tcw_pkg::REQ_CLEAR: begin
          for (int unsigned i = 0; i < nc * nr; i++) cells[i] = blank;
          cur_col = 0;
          cur_row = 0;
        end
        tcw_pkg::REQ_READ: rep.read_data = cells[req.read_addr];
        default: ;
      endcase
      rep.cursor_offset = 12'(cur_row * nc + cur_col);
      console_reports.push_back(rep);
    endfunction

    function void check_result(tcw_pkg::tcw_out_t got);
      tcw_pkg::tcw_out_t want;
      if (console_reports.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("result with none pending: cursor_offset %0d read_data 0x%04h",
                 got.cursor_offset, got.read_data);
        return;
      end
      want = console_reports.pop_front();
      checked++;
      if (got.cursor_offset !== want.cursor_offset) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("cursor_offset: expected %0d, actual %0d",
                 want.cursor_offset, got.cursor_offset);
      end
      if (got.read_data !== want.read_data) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("read_data: expected 0x%04h, actual 0x%04h",
                 want.read_data, got.read_data);
      end
    endfunction

    function int pending();
      return console_reports.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  tcw_pkg::tcw_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  tcw_pkg::tcw_out_t out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;

  screen_scoreboard sb;
  bit quiet_in;
  bit quiet_out;
  int requests;
  int settings;
  int cycle_count;

  text_console_writer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: FAIL");
    $finish;
  end

  // result side: random stalls, one check per transfer
  initial begin
    int stall;
    out_ready_i = 1'b0;
    quiet_out = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready_i <= 1'b1;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
      sb.check_result(out_data_o);
    end
  end

  // starts and ends at a falling edge
  task automatic send_req(input tcw_pkg::req_e kind, input logic [7:0] ch,
                          input logic [11:0] addr);
    int gap;
    tcw_pkg::tcw_in_t d;
    d.req_type = kind;
    d.char_code = (kind == tcw_pkg::REQ_PROC || kind == tcw_pkg::REQ_RAW) ? ch
                                                                         : 8'($urandom);
    d.read_addr = (kind == tcw_pkg::REQ_READ) ? addr : 12'($urandom);
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data_i <= d;
    in_valid_i <= 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sb.accept_request(d);
    requests++;
    @(negedge clk);
  endtask

  task automatic color_seq(input logic [7:0] code);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_COLOR, '0);
    send_req(tcw_pkg::REQ_PROC, code, '0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // waits for the block to go idle, then reprograms the geometry and blank cell
  task automatic program_geometry(input logic [15:0] cols, input logic [15:0] rows,
                                  input logic [15:0] blank);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write(tcw_pkg::CFG_COLUMNS, cols);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_SPARE, 16'($urandom));
    cfg_write(tcw_pkg::CFG_ROWS, rows);
    cfg_write(tcw_pkg::CFG_BLANK, blank);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic random_traffic(input int n);
    int done;
    int pick;
    int area;
    done = 0;
    while (done < n) begin
      area = sb.eff_cols() * sb.eff_rows();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_req(tcw_pkg::REQ_PROC, 8'($urandom_range(32, 255)), '0);
        done += 1;
      end else if (pick < 50) begin
        send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_NL, '0);
        done += 1;
      end else if (pick < 54) begin
        send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_CR, '0);
        done += 1;
      end else if (pick < 58) begin
        send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_BS, '0);
        done += 1;
      end else if (pick < 68) begin
        color_seq(8'($urandom));
        done += 3;
      end else if (pick < 72) begin
        send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
        send_req(tcw_pkg::REQ_PROC, 8'($urandom), '0);
        done += 2;
      end else if (pick < 82) begin
        send_req(tcw_pkg::REQ_RAW, 8'($urandom), '0);
        done += 1;
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0)
          send_req(tcw_pkg::REQ_READ, '0, 12'($urandom_range(0, area - 1)));
        else
          send_req(tcw_pkg::REQ_READ, '0, 12'($urandom));
        done += 1;
      end else if (pick < 96) begin
        send_req(tcw_pkg::REQ_CLEAR, '0, '0);
        done += 1;
      end else begin
        send_req(tcw_pkg::REQ_PROC, 8'($urandom), '0);
        done += 1;
      end
    end
  endtask

  initial begin
    logic [15:0] cols;
    logic [15:0] rows;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tcw_pkg::CFG_COLUMNS;
    cfg_data_i = '0;
    quiet_in = 1'b0;
    requests = 0;
    settings = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed, at the reset geometry
    send_req(tcw_pkg::REQ_READ, '0, 12'h000);
    send_req(tcw_pkg::REQ_READ, '0, 12'hFFF);
    send_req(tcw_pkg::REQ_PROC, 8'h41, '0);
    send_req(tcw_pkg::REQ_RAW, 8'h00, '0);
    send_req(tcw_pkg::REQ_RAW, 8'hFF, '0);
    send_req(tcw_pkg::REQ_RAW, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_BS, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_CR, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_BS, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_NL, '0);
    color_seq(8'hFF);
    send_req(tcw_pkg::REQ_PROC, 8'h80, '0);
    color_seq(8'h00);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_PROC, 8'h78, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_NL, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_ESC, '0);
    send_req(tcw_pkg::REQ_READ, '0, 12'd80);
    send_req(tcw_pkg::REQ_CLEAR, '0, '0);
    send_req(tcw_pkg::REQ_READ, '0, 12'h000);

    // geometry extremes
    program_geometry(16'h0000, 16'h0000, 16'hFFFF);
    random_traffic(60);
    program_geometry(16'hFFFF, 16'hFFFF, 16'h0000);
    random_traffic(30);
    program_geometry(16'd128, 16'd32, 16'($urandom));
    repeat (33) send_req(tcw_pkg::REQ_PROC, tcw_pkg::CH_NL, '0);
    random_traffic(30);
    program_geometry(16'd1, 16'd32, 16'($urandom));
    random_traffic(60);
    program_geometry(16'd128, 16'd1, 16'($urandom));
    random_traffic(60);

    for (int p = 0; p < 11; p++) begin
      cols = 16'($urandom);
      rows = 16'($urandom);
      case ($urandom_range(0, 7))
        0: begin
          cols[7:0] = 8'd0;
          rows[5:0] = 6'($urandom_range(1, 8));
        end
        1: begin
          cols[7:0] = 8'($urandom_range(1, 12));
          rows[5:0] = 6'($urandom_range(33, 63));
        end
        2: begin
          cols[7:0] = 8'($urandom_range(1, 24));
          rows[5:0] = 6'd0;
        end
        default: begin
          cols[7:0] = 8'($urandom_range(1, 24));
          rows[5:0] = 6'($urandom_range(1, 10));
        end
      endcase
      program_geometry(cols, rows, 16'($urandom));
      random_traffic(150);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb: %0d requests over %0d geometry settings, %0d results checked",
             requests, settings, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: text_console_writer_top.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_mac.sv
rtl/tcw_seq.sv
rtl/text_console_writer_top.sv
bench/tb.sv
